// ===== hdl/csrmam_pkg.sv =====
// Package for the CSR sparse matrix assemble and multiply unit.
// Holds payload structs, command and status codes, controller types and saturation.
// No dependencies.
package csrmam_pkg;

    localparam int PTR_W  = 14;
    localparam int ROW_W  = 11;
    localparam int COL_W  = 10;
    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        CMD_LOAD_RP   = 4'd0,
        CMD_LOAD_COL  = 4'd1,
        CMD_LOAD_X    = 4'd2,
        CMD_CLEAR     = 4'd3,
        CMD_ASSEMBLE  = 4'd4,
        CMD_IDENTITY  = 4'd5,
        CMD_ROW_ZERO  = 4'd6,
        CMD_PRODUCT   = 4'd7,
        CMD_READ      = 4'd8
    } cmd_e;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_SAT  = 2'd2
    } stat_e;

    typedef struct packed {
        logic [3:0]               cmd;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         column_index;
        logic [PTR_W-1:0]         entry_position;
        logic signed [DATA_W-1:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_CLEAR, S_BND0, S_BND1, S_WALK,
        S_LOOK, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_DONE
    } state_e;

    typedef struct packed {
        logic accept;
        logic clr_init;
        logic clr_step;
        logic do_load;
        logic rd_lo;
        logic rd_hi;
        logic take_start;
        logic take_stop;
        logic rd_elem;
        logic look;
        logic mul1;
        logic mul2;
        logic mul3;
        logic acc;
        logic adv;
        logic rd_slot;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic       row_ok;
        logic       clr_last;
        logic       walk_end;
        logic       hit;
        logic       out_free;
    } dp_stat_t;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/csrmam_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module csrmam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]        wdata,
    input  logic                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/csrmam_ctrl.sv =====
// Controller state machine for the CSR matrix unit.
// Depends on csrmam_pkg; drives the datapath through ctrl_t, reads dp_stat_t.
module csrmam_ctrl
    import csrmam_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output ctrl_t    ctrl
);
    state_e state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_INIT: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.accept = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    CMD_LOAD_RP, CMD_LOAD_COL, CMD_LOAD_X: begin
                        ctrl.do_load = 1'b1;
                        state_next   = S_DONE;
                    end
                    CMD_CLEAR: begin
                        ctrl.clr_init = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    CMD_ASSEMBLE, CMD_IDENTITY, CMD_ROW_ZERO, CMD_PRODUCT: begin
                        if (stat.row_ok) begin
                            ctrl.rd_lo = 1'b1;
                            state_next = S_BND0;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_READ: begin
                        ctrl.rd_slot = 1'b1;
                        state_next   = S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLEAR: begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_DONE;
                end
            end
            S_BND0: begin
                ctrl.take_start = 1'b1;
                ctrl.rd_hi      = 1'b1;
                state_next      = S_BND1;
            end
            S_BND1: begin
                ctrl.take_stop = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK: begin
                if (stat.walk_end) begin
                    state_next = S_DONE;
                end else begin
                    ctrl.rd_elem = 1'b1;
                    state_next   = S_LOOK;
                end
            end
            S_LOOK: begin
                ctrl.look = 1'b1;
                case (stat.cmd)
                    CMD_ASSEMBLE: begin
                        if (stat.hit) begin
                            state_next = S_DONE;
                        end else begin
                            ctrl.adv   = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    CMD_PRODUCT: begin
                        state_next = S_MUL1;
                    end
                    default: begin
                        ctrl.adv   = 1'b1;
                        state_next = S_WALK;
                    end
                endcase
            end
            S_MUL1: begin
                ctrl.mul1  = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                ctrl.mul2  = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3: begin
                ctrl.mul3  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                ctrl.acc   = 1'b1;
                ctrl.adv   = 1'b1;
                state_next = S_WALK;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/csrmam_dp.sv =====
// Datapath of the CSR matrix unit: stores, row walk pointer, multiply chain,
// accumulator, scale register and result register. Depends on csrmam_pkg, csrmam_ram.
module csrmam_dp
    import csrmam_pkg::*;
#(
    parameter int ROWS          = 1024,
    parameter int NONZEROS      = 8192,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  in_item_t                 s_payload,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_payload,
    input  logic                     cfg_valid,
    input  logic signed [DATA_W-1:0] cfg_data,
    input  ctrl_t                    ctrl,
    output dp_stat_t                 stat
);
    localparam int RSAW = $clog2(ROWS + 1);
    localparam int XAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NZAW = (NONZEROS > 1) ? $clog2(NONZEROS) : 1;
    localparam int NZW  = $clog2(NONZEROS + 1);
    localparam int ACCW = 33 + NZW;
    localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRACTION_BITS;

    in_item_t                 item_reg;
    logic signed [DATA_W-1:0] scale_reg;
    logic [NZW-1:0]           p_reg, stop_reg;
    logic [NZAW-1:0]          clr_cnt_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic                     sat_reg;
    logic [1:0]               stat_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     xok_reg;
    logic signed [63:0]       prod_reg, tprod_reg;
    logic signed [DATA_W-1:0] psat_reg;
    logic                     m_valid_reg;
    out_item_t                m_payload_reg;

    logic [31:0]              row_ext, slot_ext, col_ext, rs_ext, rs_clamp;
    logic [PTR_W-1:0]         rs_rdata;
    logic [COL_W-1:0]         col_rdata;
    logic [DATA_W-1:0]        val_rdata, x_rdata, val_wdata;
    logic [RSAW-1:0]          rs_raddr;
    logic [NZAW-1:0]          val_waddr, val_raddr;
    logic                     val_we, rs_we, col_we, x_we;
    logic                     hit, id_hit;
    logic signed [DATA_W-1:0] x_op;
    sat_t                     add_s, p_s, t_s, fin_s;
    out_item_t                out_next;

    assign row_ext  = 32'(item_reg.row_index);
    assign slot_ext = 32'(item_reg.entry_position);
    assign col_ext  = 32'(item_reg.column_index);
    assign rs_ext   = 32'(rs_rdata);
    assign rs_clamp = (rs_ext > NONZEROS) ? 32'(NONZEROS) : rs_ext;
    assign rs_raddr = ctrl.rd_hi ? RSAW'(row_ext + 32'd1) : row_ext[RSAW-1:0];

    assign rs_we  = ctrl.do_load && item_reg.cmd == CMD_LOAD_RP && row_ext <= ROWS;
    assign col_we = ctrl.do_load && item_reg.cmd == CMD_LOAD_COL && slot_ext < NONZEROS;
    assign x_we   = ctrl.do_load && item_reg.cmd == CMD_LOAD_X && col_ext < ROWS;

    assign hit    = col_rdata == item_reg.column_index;
    assign id_hit = {1'b0, col_rdata} == item_reg.row_index;
    assign add_s  = sat32(64'($signed(val_rdata)) + 64'(item_reg.data_value));

    always_comb begin
        val_we    = 1'b0;
        val_waddr = p_reg[NZAW-1:0];
        val_wdata = '0;
        if (ctrl.clr_step) begin
            val_we    = 1'b1;
            val_waddr = clr_cnt_reg;
        end else if (ctrl.look) begin
            case (item_reg.cmd)
                CMD_ASSEMBLE: begin
                    val_we    = hit;
                    val_wdata = add_s.val;
                end
                CMD_IDENTITY: begin
                    val_we    = 1'b1;
                    val_wdata = id_hit ? ONE : '0;
                end
                CMD_ROW_ZERO: begin
                    val_we = 1'b1;
                end
                default: begin
                    val_we = 1'b0;
                end
            endcase
        end
    end

    assign val_raddr = ctrl.rd_slot ? slot_ext[NZAW-1:0] : p_reg[NZAW-1:0];

    csrmam_ram #(.WIDTH(PTR_W), .DEPTH(ROWS + 1)) u_rs (
        .aclk(aclk), .we(rs_we), .waddr(row_ext[RSAW-1:0]),
        .wdata(item_reg.entry_position), .re(ctrl.rd_lo | ctrl.rd_hi),
        .raddr(rs_raddr), .rdata(rs_rdata)
    );

    csrmam_ram #(.WIDTH(COL_W), .DEPTH(NONZEROS)) u_col (
        .aclk(aclk), .we(col_we), .waddr(slot_ext[NZAW-1:0]),
        .wdata(item_reg.column_index), .re(ctrl.rd_elem),
        .raddr(p_reg[NZAW-1:0]), .rdata(col_rdata)
    );

    csrmam_ram #(.WIDTH(DATA_W), .DEPTH(NONZEROS)) u_val (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .re(ctrl.rd_elem | ctrl.rd_slot), .raddr(val_raddr), .rdata(val_rdata)
    );

    csrmam_ram #(.WIDTH(DATA_W), .DEPTH(ROWS)) u_x (
        .aclk(aclk), .we(x_we), .waddr(col_ext[XAW-1:0]),
        .wdata(item_reg.data_value), .re(ctrl.look),
        .raddr(XAW'(32'(col_rdata))), .rdata(x_rdata)
    );

    assign x_op  = xok_reg ? $signed(x_rdata) : '0;
    assign p_s   = sat32(prod_reg >>> FRACTION_BITS);
    assign t_s   = sat32(tprod_reg >>> FRACTION_BITS);
    assign fin_s = sat32(64'(acc_reg));

    always_comb begin
        out_next = '0;
        case (item_reg.cmd)
            CMD_PRODUCT: begin
                out_next.result_value = fin_s.val;
                out_next.status = (sat_reg || fin_s.sat) ? STAT_SAT : STAT_OK;
            end
            CMD_ASSEMBLE: begin
                out_next.status = stat_reg;
            end
            CMD_READ: begin
                if (slot_ext < NONZEROS) begin
                    out_next.result_value = val_rdata;
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg   <= ONE;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                scale_reg <= cfg_data;
            end
            if (ctrl.clr_init) begin
                clr_cnt_reg <= '0;
            end else if (ctrl.clr_step) begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (ctrl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            item_reg <= s_payload;
            acc_reg  <= ACCW'(s_payload.data_value);
            sat_reg  <= 1'b0;
            stat_reg <= (s_payload.cmd == CMD_ASSEMBLE) ? STAT_MISS : STAT_OK;
        end
        if (ctrl.take_start) begin
            p_reg <= rs_clamp[NZW-1:0];
        end
        if (ctrl.take_stop) begin
            stop_reg <= rs_clamp[NZW-1:0];
        end
        if (ctrl.adv) begin
            p_reg <= p_reg + 1'b1;
        end
        if (ctrl.look) begin
            val_reg <= $signed(val_rdata);
            xok_reg <= 32'(col_rdata) < ROWS;
            if (item_reg.cmd == CMD_ASSEMBLE && hit) begin
                stat_reg <= add_s.sat ? STAT_SAT : STAT_OK;
            end
        end
        if (ctrl.mul1) begin
            prod_reg <= val_reg * x_op;
        end
        if (ctrl.mul2) begin
            psat_reg <= p_s.val;
            sat_reg  <= sat_reg | p_s.sat;
        end
        if (ctrl.mul3) begin
            tprod_reg <= scale_reg * psat_reg;
        end
        if (ctrl.acc) begin
            acc_reg <= acc_reg + ACCW'(t_s.val);
            sat_reg <= sat_reg | t_s.sat;
        end
        if (ctrl.finish) begin
            m_payload_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign stat.cmd      = item_reg.cmd;
    assign stat.row_ok   = row_ext < ROWS;
    assign stat.clr_last = clr_cnt_reg == NZAW'(NONZEROS - 1);
    assign stat.walk_end = p_reg >= stop_reg;
    assign stat.hit      = hit;
    assign stat.out_free = !m_valid_reg || m_ready;
endmodule

// ===== hdl/csr_matrix_assemble_and_multiply_unit.sv =====
// Sparse matrix unit in compressed-row form, Q16.16 fixed point. One command per transfer
// gives one result. Row commands walk the nonzeros of the row through the single read port
// of the column and value stores; assemble stops at the first matching column, and the row
// product passes each nonzero through the two-multiplier chain. A clear command writes zero
// to all NONZEROS values; after reset the same clearing pass runs with s_ready low.
// Configuration writes are always taken. Depends on csrmam_pkg, csrmam_ctrl, csrmam_dp.
module csr_matrix_assemble_and_multiply_unit
    import csrmam_pkg::*;
#(
    parameter int ROWS          = 1024,
    parameter int NONZEROS      = 8192,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_payload,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_payload,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic signed [DATA_W-1:0] cfg_data
);
    ctrl_t    ctrl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    csrmam_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .ctrl(ctrl)
    );

    csrmam_dp #(
        .ROWS(ROWS), .NONZEROS(NONZEROS), .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .ctrl(ctrl), .stat(stat)
    );

    a_init_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input taken during reset clearing");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");
    a_finish_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |-> (!m_valid || m_ready))
        else $error("result overwrites a pending transfer");
endmodule
